// ----- rtl/core/binary_to_decimal_ascii_macros.svh -----
// Assertion macros for the decimal print block
`ifndef BINARY_TO_DECIMAL_ASCII_MACROS_SVH
`define BINARY_TO_DECIMAL_ASCII_MACROS_SVH

// same-cycle implication
`define B2DA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define B2DA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/core/b2da_pkg.sv -----
package b2da_pkg;

    localparam int VALUE_W    = 32;
    localparam int NUM_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int CHAR_W     = 6;
    localparam int STEP_W     = $clog2(VALUE_W);
    localparam int REM_W      = $clog2(NUM_DIGITS + 1);

    localparam logic [STEP_W-1:0]  LAST_STEP  = STEP_W'(VALUE_W - 1);
    localparam logic [REM_W-1:0]   ALL_DIGITS = REM_W'(NUM_DIGITS);
    localparam logic [REM_W-1:0]   ONE_DIGIT  = REM_W'(1);
    localparam logic [CHAR_W-1:0]  ASCII_ZERO = 6'd48;
    localparam logic [CHAR_W-1:0]  ASCII_NINE = 6'd57;
    localparam logic [DIGIT_W-1:0] DIGIT_FIVE = 4'd5;
    localparam logic [DIGIT_W-1:0] DIGIT_ADJ  = 4'd3;

    typedef logic [DIGIT_W-1:0] digit_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_CLEAR,
        CELL_DABBLE,
        CELL_SHIFT
    } cell_op_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SKIP,
        ST_EMIT
    } state_t;

endpackage

// ----- rtl/core/b2da_cell.sv -----
module b2da_cell
    import b2da_pkg::*;
(
    input  logic     clk,
    input  cell_op_t op,
    input  logic     carry_in,
    input  digit_t   digit_in,
    output digit_t   digit,
    output logic     carry_out
);

    digit_t digit_reg;
    digit_t digit_next;
    digit_t adj;

    // add-3 correction ahead of the shift
    assign adj       = (digit_reg >= DIGIT_FIVE) ? digit_reg + DIGIT_ADJ : digit_reg;
    assign carry_out = adj[DIGIT_W-1];
    assign digit     = digit_reg;

    always_comb
    begin
        unique case (op)
            CELL_HOLD:   digit_next = digit_reg;
            CELL_CLEAR:  digit_next = '0;
            CELL_DABBLE: digit_next = {adj[DIGIT_W-2:0], carry_in};
            CELL_SHIFT:  digit_next = digit_in;
            default:     digit_next = digit_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        digit_reg <= digit_next;
    end

endmodule

// ----- rtl/core/binary_to_decimal_ascii.sv -----
// Unsigned 32-bit binary to decimal ASCII digits.
// Command channel: value is taken at a clock edge with start high and busy
// low; busy then stays high until the item's last digit has been issued.
// Result channel: one digit per cycle on digit_char, marked by strobe, most
// significant first, no leading zeros (zero gives a single '0'); last flags
// the least significant digit. There is no back-pressure: every strobed
// digit is a transfer and the receiver must take it.
// Timing: a row of ten BCD digit cells runs 32 shift-and-adjust steps,
// then shifts out the 10 - n leading zeros, moves from ST_SKIP to ST_EMIT
// and shifts out the n digits of an n-digit result, one per cycle, back to
// back. busy falls on the edge that puts out the last digit, and only then
// can the next item be taken. The 32-step conversion loop through the cell
// row runs for every item, whatever its number of digits.
// Reset clears the sequencer and the strobe; any item in flight is dropped.
module binary_to_decimal_ascii
    import b2da_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [VALUE_W-1:0] value,
    output logic               strobe,
    output logic [CHAR_W-1:0]  digit_char,
    output logic               last
);

`include "binary_to_decimal_ascii_macros.svh"

    state_t              state_reg, state_next;
    logic [STEP_W-1:0]   step_reg, step_next;
    logic [REM_W-1:0]    rem_reg, rem_next;
    logic [VALUE_W-1:0]  value_reg, value_next;
    logic                strobe_reg, strobe_next;
    logic                last_reg, last_next;
    logic [CHAR_W-1:0]   char_reg, char_next;
    cell_op_t            op;

    digit_t cell_digit [NUM_DIGITS];
    logic   cell_carry [NUM_DIGITS];
    digit_t top_digit;

    genvar i;
    generate
        for (i = 0; i < NUM_DIGITS; i++)
        begin : g_cell
            if (i == 0)
            begin : g_first
                b2da_cell u_cell (
                    .clk       (clk),
                    .op        (op),
                    .carry_in  (value_reg[VALUE_W-1]),
                    .digit_in  ('0),
                    .digit     (cell_digit[i]),
                    .carry_out (cell_carry[i])
                );
            end
            else
            begin : g_rest
                b2da_cell u_cell (
                    .clk       (clk),
                    .op        (op),
                    .carry_in  (cell_carry[i-1]),
                    .digit_in  (cell_digit[i-1]),
                    .digit     (cell_digit[i]),
                    .carry_out (cell_carry[i])
                );
            end
        end
    endgenerate

    assign top_digit = cell_digit[NUM_DIGITS-1];

    always_comb
    begin
        state_next  = state_reg;
        step_next   = step_reg;
        rem_next    = rem_reg;
        value_next  = value_reg;
        strobe_next = 1'b0;
        last_next   = last_reg;
        char_next   = char_reg;
        op          = CELL_HOLD;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    value_next = value;
                    step_next  = '0;
                    op         = CELL_CLEAR;
                    state_next = ST_CONV;
                end
            end
            ST_CONV:
            begin
                op         = CELL_DABBLE;
                value_next = {value_reg[VALUE_W-2:0], 1'b0};
                step_next  = step_reg + 1'b1;
                if (step_reg == LAST_STEP)
                begin
                    rem_next   = ALL_DIGITS;
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP:
            begin
                if (top_digit == '0 && rem_reg != ONE_DIGIT)
                begin
                    op       = CELL_SHIFT;
                    rem_next = rem_reg - 1'b1;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                op          = CELL_SHIFT;
                strobe_next = 1'b1;
                char_next   = ASCII_ZERO + CHAR_W'(top_digit);
                last_next   = (rem_reg == ONE_DIGIT);
                rem_next    = rem_reg - 1'b1;
                if (rem_reg == ONE_DIGIT)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            strobe_reg <= strobe_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        rem_reg   <= rem_next;
        value_reg <= value_next;
        last_reg  <= last_next;
        char_reg  <= char_next;
    end

    assign busy       = (state_reg != ST_IDLE);
    assign strobe     = strobe_reg;
    assign digit_char = char_reg;
    assign last       = last_reg;

    `B2DA_ASSERT_NXT(a_run_continues, strobe && !last, strobe, "digit run broken")
    `B2DA_ASSERT_NXT(a_run_closes, strobe && last, !strobe, "digit after last")
    `B2DA_ASSERT_IMP(a_done_with_last, $fell(busy), strobe && last, "busy fell off run end")
    `B2DA_ASSERT_IMP(a_char_range, strobe,
        digit_char >= ASCII_ZERO && digit_char <= ASCII_NINE, "non-digit char")

endmodule
